[rtl/iir_filter_direct_form_defines.svh]
// Assertion macros used by the checker file of the IIR filter block.
`ifndef IIR_FILTER_DIRECT_FORM_DEFINES_SVH
`define IIR_FILTER_DIRECT_FORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define IIRDF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iirdf check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define IIRDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iirdf check failed: next-cycle implication");

`endif

[rtl/iirdf_pkg.sv]
// Shared types and constants of the IIR filter block.
`default_nettype none

package iirdf_pkg;

  // Fixed widths of the register file and arithmetic.
  localparam int COEF_W      = 32;
  localparam int ACC_W       = 64;
  localparam int ORDER_W     = 2;
  localparam int ORDER_LIMIT = (1 << ORDER_W) - 1;
  localparam int TERM_W      = 3;   // holds 2*ORDER_LIMIT
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_COEF_REGS = 3; // coefficient registers per polynomial

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_0   = 3'd4;

  // Input command codes.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic              clear;     // zero both histories
    logic              load;      // shift histories, insert sample, latch order
    logic              issue;     // multiply one term
    logic [TERM_W-1:0] term;      // term index: tap in upper bits, den in bit 0
    logic              last;      // final term; latch divisor
    logic              mag;       // take magnitudes
    logic              check;     // range check, seed divider
    logic              div_step;  // one quotient bit
    logic              finish;    // load result, write output history
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [ORDER_W-1:0] order;    // effective order of the current sample
    logic               out_free; // result register can take a new value
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/iirdf_in_if.sv]
// Input channel interface: command and sample with valid/ready.
`default_nettype none

interface iirdf_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output command, output sample_in, input ready);
  modport sink   (input valid, input command, input sample_in, output ready);
endinterface

`default_nettype wire

[rtl/iirdf_out_if.sv]
// Result channel interface: filtered sample and saturation flag with valid/ready.
`default_nettype none

interface iirdf_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

[rtl/iir_filter_direct_form.sv]
// Top level of the direct-form I IIR filter, order 0 to 2.
//
//   Channel | Direction | Payload                          | Handshake
//   in_ch   | sink      | command, sample_in               | valid/ready
//   out_ch  | source    | sample_out, saturated            | valid/ready
//   cfg     | sink      | cfg_index, cfg_wdata             | cfg_wr_en, no stall
//
// A filter transaction occupies the block from acceptance until its result is loaded:
// one shared multiplier takes one term a cycle, and the restoring divider yields one
// quotient bit a cycle.
// A clear transaction completes as it is accepted and delivers nothing.
// rst_n is synchronous: it zeroes both histories and loads the register defaults.
// A stalled result holds in the output register; the next transaction runs meanwhile
// and waits at its last step until the output register frees up.
`default_nettype none

module iir_filter_direct_form #(
  parameter int MAX_ORDER      = 2,
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  iirdf_in_if.sink                            in_ch,
  iirdf_out_if.source                         out_ch,
  input  logic                                cfg_wr_en,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf_pkg::COEF_W-1:0]        cfg_wdata
);

  iirdf_pkg::dp_cmd_t    cmd;
  iirdf_pkg::dp_status_t status;

  // Sequence each transaction: a clear at once, a filter through MAC terms, drain, magnitudes, divide, deliver.
  iirdf_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // Hold registers and histories, compute the result, drive the result channel.
  iirdf_dp #(
    .MAX_ORDER      (MAX_ORDER),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_sample     (in_ch.sample_in),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_sample    (out_ch.sample_out),
    .out_saturated (out_ch.saturated)
  );

endmodule

`default_nettype wire

[rtl/iirdf_ctrl.sv]
// Sequencing state machine of the IIR filter: MAC terms, divide, deliver.
`default_nettype none

module iirdf_ctrl #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_ready,
  output iirdf_pkg::dp_cmd_t     cmd,
  input  iirdf_pkg::dp_status_t  status
);

  localparam int CNT_W = $clog2(SAMPLE_WIDTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAC   = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_MAG   = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [iirdf_pkg::TERM_W-1:0]    term_r, term_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [iirdf_pkg::TERM_W-1:0]    last_term;

  assign in_ready  = (state_r == S_IDLE);
  assign last_term = {status.order, 1'b0};

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.term  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == iirdf_pkg::CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            term_nxt  = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (term_r == last_term) begin
          cmd.last  = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = CNT_W'(SAMPLE_WIDTH - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/iirdf_dp.sv]
// Datapath of the IIR filter: registers, histories, shared MAC, divider, result register.
`default_nettype none

module iirdf_dp #(
  parameter int MAX_ORDER      = 2,
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iirdf_pkg::COEF_W-1:0]           cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  iirdf_pkg::dp_cmd_t                     cmd,
  output iirdf_pkg::dp_status_t                  status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         out_sample,
  output logic                                   out_saturated
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CW      = iirdf_pkg::COEF_W;
  localparam int AW      = iirdf_pkg::ACC_W;
  localparam int OW      = iirdf_pkg::ORDER_W;
  localparam int EFF_MAX = (MAX_ORDER < iirdf_pkg::ORDER_LIMIT) ? MAX_ORDER
                                                                : iirdf_pkg::ORDER_LIMIT;
  localparam int DEPTH   = EFF_MAX + 1;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam logic [SW-1:0] LIM_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] LIM_NEG = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] DEN_ONE = CW'(64'd1 << COEF_FRAC_BITS);

  // Configuration registers
  logic [OW-1:0]        order_r;
  logic signed [CW-1:0] num_r [DEPTH];
  logic signed [CW-1:0] den_r [DEPTH];

  // Histories
  logic signed [SW-1:0] xh_r [DEPTH];
  logic signed [SW-1:0] yh_r [DEPTH];

  // Working registers
  logic [OW-1:0]        n_r;
  logic signed [AW-1:0] prod_r;
  logic                 prod_vld_r;
  logic                 prod_sub_r;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic signed [CW-1:0] div_r;
  logic [AW-1:0]        mag_r;
  logic [CW-1:0]        dmag_r;
  logic                 neg_r;
  logic                 big_r;
  logic                 dz_r;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [SW-1:0]        low_r;
  logic                 out_valid_r;
  logic [SW-1:0]        out_sample_r;
  logic                 out_sat_r;

  logic [OW-1:0]        n_ld;
  logic [OW-1:0]        tap;
  logic [IDX_W-1:0]     idx;
  logic                 is_den;
  logic signed [CW-1:0]    coef_op;
  logic signed [SW-1:0]    hist_op;
  logic signed [CW+SW-1:0] mul;
  logic [CW:0]          trial;
  logic                 ge;
  logic [SW-1:0]        lim;
  logic                 over;
  logic [SW-1:0]        qs;
  logic [SW-1:0]        res;
  logic                 sat;

  assign n_ld   = (order_r > OW'(EFF_MAX)) ? OW'(EFF_MAX) : order_r;
  assign tap    = cmd.term[iirdf_pkg::TERM_W-1:1];
  assign idx    = tap[IDX_W-1:0];
  assign is_den = cmd.term[0];

  assign coef_op = is_den ? den_r[idx] : num_r[idx];
  assign hist_op = is_den ? yh_r[idx]  : xh_r[idx];
  assign mul     = coef_op * hist_op;

  assign acc_nxt = prod_sub_r ? (acc_r - prod_r) : (acc_r + prod_r);

  assign trial   = {rem_r, low_r[SW-1]} - {1'b0, dmag_r};
  assign ge      = !trial[CW];
  assign rem_nxt = ge ? trial[CW-1:0] : {rem_r[CW-2:0], low_r[SW-1]};

  // Clip the quotient magnitude, then restore the sign; a zero divisor gives zero, flagged saturated.
  always_comb begin
    lim  = neg_r ? LIM_NEG : LIM_POS;
    over = big_r || (low_r > lim);
    qs   = over ? lim : low_r;
    if (dz_r) begin
      res = '0;
      sat = 1'b1;
    end else begin
      res = neg_r ? (-qs) : qs;
      sat = over;
    end
  end

  assign status.order    = n_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_saturated = out_sat_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      for (int k = 0; k < DEPTH; k++) begin
        num_r[k] <= '0;
        den_r[k] <= (k == 0) ? DEN_ONE : '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == iirdf_pkg::REG_FILTER_ORDER) begin
        order_r <= cfg_wdata[OW-1:0];
      end
      for (int k = 0; k < DEPTH; k++) begin
        if (k < iirdf_pkg::NUM_COEF_REGS &&
            cfg_index == iirdf_pkg::REG_NUM_COEF_0 + iirdf_pkg::CFG_IDX_W'(k)) begin
          num_r[k] <= cfg_wdata;
        end
        if (k < iirdf_pkg::NUM_COEF_REGS &&
            cfg_index == iirdf_pkg::REG_DEN_COEF_0 + iirdf_pkg::CFG_IDX_W'(k)) begin
          den_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // Histories
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (i < int'(n_ld)) begin
            xh_r[i] <= xh_r[i+1];
            yh_r[i] <= yh_r[i+1];
          end
        end
        xh_r[n_ld[IDX_W-1:0]] <= in_sample;
      end
      if (cmd.finish) begin
        yh_r[n_r[IDX_W-1:0]] <= res;
      end
    end
  end

  // Control flags of the working path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      prod_vld_r <= cmd.issue;
      if (cmd.load) begin
        n_r <= n_ld;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Arithmetic payload
  always_ff @(posedge clk) begin
    prod_r     <= AW'(mul);
    prod_sub_r <= is_den;
    if (cmd.load) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.issue && cmd.last) begin
      div_r <= den_r[idx];
    end
    if (cmd.mag) begin
      mag_r  <= acc_r[AW-1] ? (-acc_r) : acc_r;
      dmag_r <= div_r[CW-1] ? (-div_r) : div_r;
      neg_r  <= acc_r[AW-1] ^ div_r[CW-1];
    end
    if (cmd.check) begin
      big_r <= (mag_r >> SW) >= {{(AW-CW){1'b0}}, dmag_r};
      dz_r  <= (dmag_r == '0);
      rem_r <= mag_r[SW+CW-1:SW];
      low_r <= mag_r[SW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[SW-2:0], ge};
    end
    if (cmd.finish) begin
      out_sample_r <= res;
      out_sat_r    <= sat;
    end
  end

endmodule

`default_nettype wire

[rtl/iirdf_checker.sv]
// Port-level checker of the IIR filter and its bind to the top level.
`default_nettype none
`include "iir_filter_direct_form_defines.svh"

module iirdf_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_command,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                    out_saturated
);

  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic filt_acc;
  logic clr_acc;
  logic out_stall;
  logic clip_ok;

  assign filt_acc  = in_valid && in_ready && (in_command == iirdf_pkg::CMD_FILTER);
  assign clr_acc   = in_valid && in_ready && (in_command == iirdf_pkg::CMD_CLEAR);
  assign out_stall = out_valid && !out_ready;
  assign clip_ok   = (out_sample_out == '0) || (out_sample_out == SMAX) ||
                     (out_sample_out == SMIN);

  // A stalled result stays offered.
  `IIRDF_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
  // A filter transaction keeps the block busy for the next cycle.
  `IIRDF_ASSERT_NEXT(a_filter_busy, filt_acc, !in_ready)
  // A clear completes at once and leaves the input open.
  `IIRDF_ASSERT_NEXT(a_clear_quick, clr_acc, in_ready)
  // A saturated result is zero or a full-scale value.
  `IIRDF_ASSERT_IMPL(a_sat_value, out_valid && out_saturated, clip_ok)

endmodule

bind iir_filter_direct_form iirdf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_command     (in_ch.command),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample_out (out_ch.sample_out),
  .out_saturated  (out_ch.saturated)
);

`default_nettype wire
